@@ rtl/calendar_date_arithmetic_assert.svh @@
// Assertion macros for the date block; the clock and reset are the block's own.
`ifndef CALENDAR_DATE_ARITHMETIC_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_ASSERT_SVH

`ifndef SYNTHESIS
`define CDA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define CDA_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define CDA_ASSERT_ALWAYS(lbl, cond, msg)
`define CDA_ASSERT_PROP(lbl, prop, msg)
`endif

`endif

@@ rtl/cda_pkg.sv @@
package cda_pkg;

  localparam int STEP_BITS = 17;
  localparam int MIN_YEAR  = 1900;
  localparam int YEAR_W    = 16;
  localparam int YEAR_MAX  = (1 << YEAR_W) - 1;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int FUNC_W    = 3;
  localparam int WDAY_W    = 3;
  localparam int MONTHS    = 12;
  localparam int LAST_DAY  = 31;

  // Gregorian cycle and its remainder register width
  localparam int ERA       = 400;
  localparam int ERA_W     = $clog2(ERA);
  localparam int MIN_R400  = MIN_YEAR % ERA;
  localparam int ERA_Q_W   = $clog2(YEAR_MAX / ERA + 1);
  // year / 400 as (year >> 4) / 25, the latter by a rounded-up reciprocal
  localparam int ERA_POW2  = 4;
  localparam int ERA_ODD   = ERA >> ERA_POW2;
  localparam int ERA_SHIFT = 17;
  localparam int ERA_RECIP = ((1 << ERA_SHIFT) + ERA_ODD - 1) / ERA_ODD;

  localparam logic [FUNC_W-1:0] FN_LOAD       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET_DAY    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET_MONTH  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_YEAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_ADD_DAYS   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_ADD_MONTHS = 3'd5;
  localparam logic [FUNC_W-1:0] FN_ADD_YEARS  = 3'd6;

  // leap test from the year modulo 400
  function automatic logic is_leap400(input logic [ERA_W-1:0] r);
    return (r[1:0] == 2'b00) && !(r == ERA_W'(100) || r == ERA_W'(200) || r == ERA_W'(300));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                                   input logic leap);
    return (m >= MONTH_W'(1)) && (m <= MONTH_W'(MONTHS)) && (d != '0) &&
           (d <= month_len(m, leap));
  endfunction

  // days from 1 March to the first of month m, year starting in March
  function automatic logic [8:0] doy_base(input logic [MONTH_W-1:0] m);
    logic [8:0] b;
    case (m)
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  // modulo 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [WDAY_W-1:0] mod7(input logic [9:0] v);
    logic [4:0] f1;
    logic [3:0] f2;
    f1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[9]);
    f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
    if (f2 >= 4'd7) begin
      f2 = f2 - 4'd7;
    end
    return f2[2:0];
  endfunction

  // weekday, 0 Monday; the 400-year cycle is a whole number of weeks
  function automatic logic [WDAY_W-1:0] weekday_of(input logic [DAY_W-1:0] d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic [ERA_W-1:0] r);
    logic [ERA_W-1:0] yoe;
    logic [1:0]       c100;
    logic [9:0]       s;
    if (m <= MONTH_W'(2)) begin
      yoe = (r == '0) ? ERA_W'(ERA - 1) : r - ERA_W'(1);
    end else begin
      yoe = r;
    end
    c100 = 2'(yoe >= ERA_W'(100)) + 2'(yoe >= ERA_W'(200)) + 2'(yoe >= ERA_W'(300));
    // 1 March of year 0 fell on a Wednesday
    s = 10'(yoe) + 10'(yoe[ERA_W-1:2]) - 10'(c100) + 10'(doy_base(m)) + 10'(d) + 10'd1;
    return mod7(s);
  endfunction

endpackage

@@ rtl/calendar_date_arithmetic.sv @@
// Gregorian date register with date arithmetic.
// Input channel (in_valid_i/in_ready_o) carries one operation word: func_i selects
// load, set day/month/year, add days, add months or add years; step_value_i is the
// signed count, new_* the date parts for load and set. Output channel
// (out_valid_o/out_ready_i) returns one word per operation: the stored date, its
// weekday (0 Monday) and ok, which is low when the operation was refused; the
// date is then left unchanged, but a refused load sets it to 1/1/1900.
// Each operation first reduces the year modulo 400 (a reciprocal multiply, then
// a multiply-subtract); add days then walks the date month by month, advancing
// one month per cycle, until the remaining step fits within the month.
// One operation is in flight at a time: in_ready_o is high only while idle, so
// a new word is not taken before the previous result has been handed to the
// output register.
// The output register holds a result until taken; a stalled receiver holds the
// next operation in its final cycle, and input acceptance resumes once it drains.
// Reset is asynchronous, active low, and sets the date to 1/1/1900 with no
// output word pending.
module calendar_date_arithmetic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [cda_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [cda_pkg::STEP_BITS-1:0] step_value_i,
  input  logic [cda_pkg::DAY_W-1:0]          new_day_i,
  input  logic [cda_pkg::MONTH_W-1:0]        new_month_i,
  input  logic [cda_pkg::YEAR_W-1:0]         new_year_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cda_pkg::DAY_W-1:0]          cur_day_o,
  output logic [cda_pkg::MONTH_W-1:0]        cur_month_o,
  output logic [cda_pkg::YEAR_W-1:0]         cur_year_o,
  output logic [cda_pkg::WDAY_W-1:0]         weekday_o,
  output logic                               ok_o
);
  import cda_pkg::*;

  `include "calendar_date_arithmetic_assert.svh"

  localparam int SUM_W = ((STEP_BITS > YEAR_W + 1) ? STEP_BITS : YEAR_W + 1) + 1;
  localparam int REM_W = STEP_BITS + 1;
  localparam int DIV_P_W = ERA_SHIFT + ERA_Q_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_WDAY  = 3'd4;

  logic [2:0]                  state_q;
  logic [FUNC_W-1:0]           func_q;
  logic signed [STEP_BITS-1:0] step_q;
  logic [DAY_W-1:0]            nd_q;
  logic [MONTH_W-1:0]          nm_q;
  logic [YEAR_W-1:0]           cy_q;
  logic                        cy_ok_q;
  logic [YEAR_W-1:0]           div_r_q;
  logic [ERA_Q_W-1:0]          div_q_q;
  logic                        div_cnt_q;

  // stored date and its year modulo 400
  logic [DAY_W-1:0]            sd_q;
  logic [MONTH_W-1:0]          sm_q;
  logic [YEAR_W-1:0]           sy_q;
  logic [ERA_W-1:0]            sr_q;

  // walk copy
  logic [DAY_W-1:0]            wd_q;
  logic [MONTH_W-1:0]          wm_q;
  logic [YEAR_W-1:0]           wy_q;
  logic [ERA_W-1:0]            wr_q;
  logic signed [STEP_BITS-1:0] rem_q;

  logic                        ok_q;
  logic                        out_valid_q;
  logic [DAY_W-1:0]            out_day_q;
  logic [MONTH_W-1:0]          out_month_q;
  logic [YEAR_W-1:0]           out_year_q;
  logic [WDAY_W-1:0]           out_wday_q;
  logic                        out_ok_q;

  // accept-time year candidate
  logic signed [SUM_W-1:0]     yr_sum;
  logic [YEAR_W-1:0]           cy_in;
  logic                        cy_ok_in;

  // year / 400 by reciprocal multiplication
  logic [DIV_P_W-1:0]          div_prod;
  logic [ERA_Q_W-1:0]          div_quo;

  // check stage
  logic [ERA_W-1:0]            div_rem;
  logic                        leap_c;
  logic signed [SUM_W-1:0]     m_sum;
  logic                        m_sum_ok;

  // walk stage
  logic                        w_leap;
  logic [DAY_W-1:0]            w_len;
  logic [DAY_W-1:0]            w_prev_len;
  logic signed [REM_W-1:0]     rem_x;
  logic signed [REM_W-1:0]     room_x;
  logic signed [REM_W-1:0]     rem_fwd;
  logic signed [REM_W-1:0]     rem_back;
  logic                        go_fwd;
  logic                        go_back;

  assign yr_sum = SUM_W'(signed'({1'b0, sy_q})) + SUM_W'(step_value_i);

  always_comb begin
    cy_in    = sy_q;
    cy_ok_in = 1'b1;
    case (func_i)
      FN_LOAD, FN_SET_YEAR: begin
        cy_in    = new_year_i;
        cy_ok_in = (32'(new_year_i) >= MIN_YEAR);
      end
      FN_ADD_YEARS: begin
        cy_in    = yr_sum[YEAR_W-1:0];
        cy_ok_in = (yr_sum >= MIN_YEAR) && (yr_sum <= YEAR_MAX);
      end
      default: begin
        cy_in    = sy_q;
        cy_ok_in = 1'b1;
      end
    endcase
  end

  assign div_prod = DIV_P_W'(cy_q[YEAR_W-1:ERA_POW2]) * DIV_P_W'(ERA_RECIP);
  assign div_quo  = div_prod[DIV_P_W-1:ERA_SHIFT];

  assign div_rem  = div_r_q[ERA_W-1:0];
  assign leap_c   = is_leap400(div_rem);
  assign m_sum    = SUM_W'(signed'({1'b0, sm_q})) + SUM_W'(step_q);
  assign m_sum_ok = (m_sum >= 1) && (m_sum <= MONTHS);

  assign w_leap     = is_leap400(wr_q);
  assign w_len      = month_len(wm_q, w_leap);
  assign w_prev_len = month_len(wm_q - MONTH_W'(1), w_leap);
  assign rem_x      = REM_W'(rem_q);
  assign room_x     = REM_W'(signed'({1'b0, w_len - wd_q}));
  assign rem_fwd    = rem_x - room_x - REM_W'(1);
  assign rem_back   = rem_x + REM_W'(signed'({1'b0, wd_q}));
  assign go_fwd     = !rem_q[STEP_BITS-1] && (rem_x > room_x);
  assign go_back    = rem_q[STEP_BITS-1] && (rem_back <= 0);

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sd_q        <= DAY_W'(1);
      sm_q        <= MONTH_W'(1);
      sy_q        <= YEAR_W'(MIN_YEAR);
      sr_q        <= ERA_W'(MIN_R400);
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q    <= func_i;
            step_q    <= step_value_i;
            nd_q      <= new_day_i;
            nm_q      <= new_month_i;
            cy_q      <= cy_in;
            cy_ok_q   <= cy_ok_in;
            div_cnt_q <= 1'b1;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          // take the quotient first, then the remainder from it
          if (div_cnt_q) begin
            div_q_q   <= div_quo;
            div_cnt_q <= 1'b0;
          end else begin
            div_r_q <= cy_q - YEAR_W'(div_q_q) * YEAR_W'(ERA);
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          ok_q    <= 1'b0;
          state_q <= S_WDAY;
          case (func_q)
            FN_LOAD: begin
              if (cy_ok_q && date_ok(nd_q, nm_q, leap_c)) begin
                sd_q <= nd_q;
                sm_q <= nm_q;
                sy_q <= cy_q;
                sr_q <= div_rem;
                ok_q <= 1'b1;
              end else begin
                sd_q <= DAY_W'(1);
                sm_q <= MONTH_W'(1);
                sy_q <= YEAR_W'(MIN_YEAR);
                sr_q <= ERA_W'(MIN_R400);
              end
            end
            FN_SET_DAY: begin
              if (date_ok(nd_q, sm_q, leap_c)) begin
                sd_q <= nd_q;
                ok_q <= 1'b1;
              end
            end
            FN_SET_MONTH: begin
              if (date_ok(sd_q, nm_q, leap_c)) begin
                sm_q <= nm_q;
                ok_q <= 1'b1;
              end
            end
            FN_SET_YEAR, FN_ADD_YEARS: begin
              if (cy_ok_q && date_ok(sd_q, sm_q, leap_c)) begin
                sy_q <= cy_q;
                sr_q <= div_rem;
                ok_q <= 1'b1;
              end
            end
            FN_ADD_MONTHS: begin
              if (m_sum_ok && date_ok(sd_q, m_sum[MONTH_W-1:0], leap_c)) begin
                sm_q <= m_sum[MONTH_W-1:0];
                ok_q <= 1'b1;
              end
            end
            FN_ADD_DAYS: begin
              wd_q    <= sd_q;
              wm_q    <= sm_q;
              wy_q    <= sy_q;
              wr_q    <= div_rem;
              rem_q   <= step_q;
              state_q <= S_WALK;
            end
            default: begin
              ok_q <= 1'b0;
            end
          endcase
        end
        S_WALK: begin
          if (go_fwd) begin
            rem_q <= rem_fwd[STEP_BITS-1:0];
            wd_q  <= DAY_W'(1);
            if (wm_q == MONTH_W'(MONTHS)) begin
              if (32'(wy_q) == YEAR_MAX) begin
                // past the last representable day: drop the walk
                state_q <= S_WDAY;
              end else begin
                wm_q <= MONTH_W'(1);
                wy_q <= wy_q + YEAR_W'(1);
                wr_q <= (wr_q == ERA_W'(ERA - 1)) ? '0 : wr_q + ERA_W'(1);
              end
            end else begin
              wm_q <= wm_q + MONTH_W'(1);
            end
          end else if (go_back) begin
            rem_q <= rem_back[STEP_BITS-1:0];
            if (wm_q == MONTH_W'(1)) begin
              if (32'(wy_q) == MIN_YEAR) begin
                state_q <= S_WDAY;
              end else begin
                wm_q <= MONTH_W'(MONTHS);
                wd_q <= DAY_W'(LAST_DAY);
                wy_q <= wy_q - YEAR_W'(1);
                wr_q <= (wr_q == '0) ? ERA_W'(ERA - 1) : wr_q - ERA_W'(1);
              end
            end else begin
              wm_q <= wm_q - MONTH_W'(1);
              wd_q <= w_prev_len;
            end
          end else begin
            // remainder fits in this month: commit
            sd_q    <= wd_q + rem_q[DAY_W-1:0];
            sm_q    <= wm_q;
            sy_q    <= wy_q;
            sr_q    <= wr_q;
            ok_q    <= 1'b1;
            state_q <= S_WDAY;
          end
        end
        S_WDAY: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WDAY && (!out_valid_q || out_ready_i)) begin
      out_day_q   <= sd_q;
      out_month_q <= sm_q;
      out_year_q  <= sy_q;
      out_wday_q  <= weekday_of(sd_q, sm_q, sr_q);
      out_ok_q    <= ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cur_day_o   = out_day_q;
  assign cur_month_o = out_month_q;
  assign cur_year_o  = out_year_q;
  assign weekday_o   = out_wday_q;
  assign ok_o        = out_ok_q;

  `CDA_ASSERT_ALWAYS(a_stored_date_valid, date_ok(sd_q, sm_q, is_leap400(sr_q)) && (32'(sy_q) >= MIN_YEAR), "stored date is not a valid date")
  `CDA_ASSERT_PROP(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "input taken while an operation is in flight")
  `CDA_ASSERT_PROP(a_div_remainder, (state_q == S_CHECK) |-> (div_r_q < YEAR_W'(ERA)), "year remainder not reduced below 400")
  `CDA_ASSERT_PROP(a_weekday_range, out_valid_o |-> (weekday_o < WDAY_W'(7)), "weekday out of range")

endmodule
